/* rtl/modular_inverse_ext_euclid_unit_macros.svh */
// Assertion macros for the modular inverse unit.
// Included by the top-level RTL file, which carries the concurrent assertions; no other dependency.
`ifndef MODULAR_INVERSE_EXT_EUCLID_UNIT_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MIEU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MIEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MIEU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MIEU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/mieu_pkg.sv */
// Shared widths, microcode types and the control store of the modular inverse unit.
// No dependencies.
`default_nettype none
package mieu_pkg;

    localparam int OPERAND_WIDTH = 31;
    localparam int DIV_WIDTH     = 2 * OPERAND_WIDTH - 1;
    localparam int COEF_WIDTH    = OPERAND_WIDTH + 2;
    localparam int ACC_WIDTH     = 2 * OPERAND_WIDTH + 2;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_CHECK,
        ST_TEST,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_ROTATE,
        ST_FINISH,
        ST_ZERO_ERR
    } step_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_START,
        COND_ZERO_OPND,
        COND_R1_ZERO,
        COND_CNT_NZ
    } cond_t;

    typedef struct packed {
        logic  load;
        logic  div_init;
        logic  div_step;
        logic  rotate;
        logic  finish;
        logic  zero_err;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic zero_opnd;
        logic r1_zero;
        logic cnt_nz;
    } status_t;

    function automatic ctrl_t ucode(step_t pc);
        ctrl_t w;
        begin
            w = '0;
            w.cond   = COND_ALWAYS;
            w.target = ST_WAIT;
            unique case (pc)
                ST_WAIT:
                begin
                    w.load   = 1'b1;
                    w.cond   = COND_NO_START;
                    w.target = ST_WAIT;
                end
                ST_CHECK:
                begin
                    w.cond   = COND_ZERO_OPND;
                    w.target = ST_ZERO_ERR;
                end
                ST_TEST:
                begin
                    w.cond   = COND_R1_ZERO;
                    w.target = ST_FINISH;
                end
                ST_DIV_INIT:
                begin
                    w.div_init = 1'b1;
                    w.cond     = COND_R1_ZERO;
                    w.target   = ST_FINISH;
                end
                ST_DIV_STEP:
                begin
                    w.div_step = 1'b1;
                    w.cond     = COND_CNT_NZ;
                    w.target   = ST_DIV_STEP;
                end
                ST_ROTATE:
                begin
                    w.rotate = 1'b1;
                    w.cond   = COND_ALWAYS;
                    w.target = ST_TEST;
                end
                ST_FINISH:
                begin
                    w.finish = 1'b1;
                    w.cond   = COND_ALWAYS;
                    w.target = ST_WAIT;
                end
                ST_ZERO_ERR:
                begin
                    w.zero_err = 1'b1;
                    w.cond     = COND_ALWAYS;
                    w.target   = ST_WAIT;
                end
                default:
                begin
                    w.cond   = COND_ALWAYS;
                    w.target = ST_WAIT;
                end
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/mieu_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on mieu_pkg.
`default_nettype none
module mieu_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mieu_pkg::status_t status,
    output mieu_pkg::ctrl_t        ctrl,
    output logic                   busy
);

    mieu_pkg::step_t pc_reg;
    mieu_pkg::step_t pc_next;
    logic            take;

    always_comb
    begin
        ctrl = mieu_pkg::ucode(pc_reg);
        busy = (pc_reg != mieu_pkg::ST_WAIT);
    end

    always_comb
    begin
        unique case (ctrl.cond)
            mieu_pkg::COND_ALWAYS:    take = 1'b1;
            mieu_pkg::COND_NO_START:  take = !start;
            mieu_pkg::COND_ZERO_OPND: take = status.zero_opnd;
            mieu_pkg::COND_R1_ZERO:   take = status.r1_zero;
            mieu_pkg::COND_CNT_NZ:    take = status.cnt_nz;
            default:                  take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : mieu_pkg::step_t'(pc_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= mieu_pkg::ST_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/mieu_dp.sv */
// Datapath: remainder and coefficient registers, shift-subtract divider with
// coefficient update folded in. Depends on mieu_pkg.
`default_nettype none
module mieu_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [mieu_pkg::OPERAND_WIDTH-1:0]    value_in,
    input  wire logic [mieu_pkg::OPERAND_WIDTH-1:0]    modulus_in,
    input  wire mieu_pkg::ctrl_t                       ctrl,
    output mieu_pkg::status_t                          status,
    output logic [mieu_pkg::OPERAND_WIDTH-1:0]         inv,
    output logic [mieu_pkg::OPERAND_WIDTH-1:0]         gcd
);

    localparam int W  = mieu_pkg::OPERAND_WIDTH;
    localparam int DW = mieu_pkg::DIV_WIDTH;
    localparam int CW = mieu_pkg::COEF_WIDTH;
    localparam int AW = mieu_pkg::ACC_WIDTH;
    localparam int NW = mieu_pkg::CNT_WIDTH;

    logic [W-1:0]         r0_reg;
    logic [W-1:0]         r1_reg;
    logic [W-1:0]         m_reg;
    logic [W-1:0]         rem_reg;
    logic [DW-1:0]        div_reg;
    logic signed [CW-1:0] c0_reg;
    logic signed [CW-1:0] c1_reg;
    logic signed [AW-1:0] cs_reg;
    logic signed [AW-1:0] acc_reg;
    logic [NW-1:0]        cnt_reg;
    logic                 ge;
    logic signed [CW-1:0] x;

    always_comb
    begin
        ge = ({{(DW-W){1'b0}}, rem_reg} >= div_reg);
        status.zero_opnd = (r0_reg == '0) || (r1_reg == '0);
        status.r1_zero   = (r1_reg == '0);
        status.cnt_nz    = (cnt_reg != '0);
        x   = c0_reg[CW-1] ? (c0_reg + signed'({2'b00, m_reg})) : c0_reg;
        inv = x[W-1:0];
        gcd = r0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.div_init)
        begin
            cnt_reg <= NW'(W - 1);
        end
        else if (ctrl.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && start)
        begin
            r0_reg <= value_in;
            r1_reg <= modulus_in;
            m_reg  <= modulus_in;
            c0_reg <= CW'(1);
            c1_reg <= '0;
        end
        if (ctrl.div_init)
        begin
            rem_reg <= r0_reg;
            div_reg <= {r1_reg, {(W-1){1'b0}}};
            cs_reg  <= {{(AW-CW){c1_reg[CW-1]}}, c1_reg} <<< (W - 1);
            acc_reg <= {{(AW-CW){c0_reg[CW-1]}}, c0_reg};
        end
        if (ctrl.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - div_reg[W-1:0];
                acc_reg <= acc_reg - cs_reg;
            end
            div_reg <= div_reg >> 1;
            cs_reg  <= cs_reg >>> 1;
        end
        if (ctrl.rotate)
        begin
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            c0_reg <= c1_reg;
            c1_reg <= acc_reg[CW-1:0];
        end
    end

endmodule
`default_nettype wire

/* rtl/modular_inverse_ext_euclid_unit.sv */
// Top level of the modular inverse unit: sequencer, datapath and result registers.
// Depends on mieu_pkg, mieu_seq, mieu_dp and the assertion macro header.
`default_nettype none
`include "modular_inverse_ext_euclid_unit_macros.svh"
// A transfer in takes place when start is high while busy is low; busy then stays
// high until the result is out. Each Euclid division runs in the shared
// shift-subtract divider, one quotient bit per operand bit, wrapped in the test,
// divider setup and rotate steps of loop control; 31-bit operands need up to about
// 46 divisions, and a zero operand skips the loop. The result is shown for exactly
// one cycle with done high and cannot be held off by the receiver.
module modular_inverse_ext_euclid_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [mieu_pkg::OPERAND_WIDTH-1:0]    value_in,
    input  wire logic [mieu_pkg::OPERAND_WIDTH-1:0]    modulus_in,
    output logic                                       done,
    output logic [mieu_pkg::OPERAND_WIDTH-1:0]         inverse_out,
    output logic [mieu_pkg::OPERAND_WIDTH-1:0]         gcd_out,
    output logic                                       invertible,
    output logic                                       zero_error
);

    mieu_pkg::ctrl_t                    ctrl;
    mieu_pkg::status_t                  status;
    logic [mieu_pkg::OPERAND_WIDTH-1:0] inv;
    logic [mieu_pkg::OPERAND_WIDTH-1:0] gcd;
    logic                               done_reg;
    logic                               done_next;
    logic [mieu_pkg::OPERAND_WIDTH-1:0] inverse_reg;
    logic [mieu_pkg::OPERAND_WIDTH-1:0] gcd_reg;
    logic                               invertible_reg;
    logic                               zero_error_reg;

    mieu_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    mieu_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value_in   (value_in),
        .modulus_in (modulus_in),
        .ctrl       (ctrl),
        .status     (status),
        .inv        (inv),
        .gcd        (gcd)
    );

    always_comb
    begin
        done_next = ctrl.finish || ctrl.zero_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            inverse_reg    <= inv;
            gcd_reg        <= gcd;
            invertible_reg <= (gcd == mieu_pkg::OPERAND_WIDTH'(1));
            zero_error_reg <= 1'b0;
        end
        else if (ctrl.zero_err)
        begin
            inverse_reg    <= '0;
            gcd_reg        <= '0;
            invertible_reg <= 1'b0;
            zero_error_reg <= 1'b1;
        end
    end

    assign done        = done_reg;
    assign inverse_out = inverse_reg;
    assign gcd_out     = gcd_reg;
    assign invertible  = invertible_reg;
    assign zero_error  = zero_error_reg;

    `MIEU_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `MIEU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)
    `MIEU_ASSERT_SAME(a_flags_exclusive, clk, rst_n, done, !(invertible && zero_error))
    `MIEU_ASSERT_SAME(a_zero_clears, clk, rst_n, done && zero_error, gcd_out == '0)

endmodule
`default_nettype wire
